>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; the bodies are empty in synthesis builds
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> rtl/asmo_pkg.sv
// ---------------------------------------------------------------------------
// asmo_pkg
// Constants and helper functions for the sample magnitude/orientation core
// ---------------------------------------------------------------------------
package asmo_pkg;

    // full-scale range select codes
    localparam logic [1:0] FS_2G  = 2'd0;
    localparam logic [1:0] FS_4G  = 2'd1;
    localparam logic [1:0] FS_8G  = 2'd2;
    localparam logic [1:0] FS_16G = 2'd3;

    // facing codes
    localparam logic [2:0] FACE_NONE  = 3'd0;
    localparam logic [2:0] FACE_POS_Z = 3'd1;
    localparam logic [2:0] FACE_NEG_Z = 3'd2;
    localparam logic [2:0] FACE_POS_Y = 3'd3;
    localparam logic [2:0] FACE_NEG_Y = 3'd4;
    localparam logic [2:0] FACE_POS_X = 3'd5;
    localparam logic [2:0] FACE_NEG_X = 3'd6;

    localparam logic [15:0] MG_THRESHOLD     = 16'd700;
    localparam int          NEWTON_MAX_STEPS = 20;
    localparam logic [15:0] MAG_SAT          = 16'hFFFF;

    typedef logic signed [15:0] t_mg;

    // left-justified 12-bit raw word to milli-g
    function automatic t_mg scale_axis(input logic [15:0] raw, input logic [1:0] code);
        logic signed [15:0] v;
        t_mg                res;
        v = {{4{raw[15]}}, raw[15:4]};
        unique case (code)
            FS_2G:   res = v;
            FS_4G:   res = v <<< 1;
            FS_8G:   res = v <<< 2;
            FS_16G:  res = (v <<< 3) + (v <<< 2);
            default: res = v;
        endcase
        return res;
    endfunction

    function automatic logic [15:0] abs_mg(input t_mg v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    // gravity face with priority z, y, x
    function automatic logic [2:0] facing_code(input t_mg x, input t_mg y, input t_mg z);
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic [2:0]  res;
        ax = abs_mg(x);
        ay = abs_mg(y);
        az = abs_mg(z);
        priority if (az >= ax && az >= ay && az > MG_THRESHOLD) begin
            res = (z > 0) ? FACE_POS_Z : FACE_NEG_Z;
        end else if (ay >= ax && ay >= az && ay > MG_THRESHOLD) begin
            res = (y > 0) ? FACE_POS_Y : FACE_NEG_Y;
        end else if (ax >= ay && ax >= az && ax > MG_THRESHOLD) begin
            res = (x > 0) ? FACE_POS_X : FACE_NEG_X;
        end else begin
            res = FACE_NONE;
        end
        return res;
    endfunction

endpackage

>>> rtl/accel_sample_magnitude_orientation_core.sv
// ---------------------------------------------------------------------------
// accel_sample_magnitude_orientation_core
// Scales one accelerometer sample to milli-g, takes the magnitude by integer
// Newton square root and reports which face points at gravity
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample word: x, y, z raw 16-bit left-justified words.
//   m_axis returns one result word per sample: scaled x, y, z, magnitude and
//   facing code. The cfg channel writes the 2-bit full-scale code; it is
//   always ready and must only be written while no sample is in flight.
// Sequencing:
//   a sample is taken, then squared and summed one axis at a time on one 16x16
//   multiplier, then each Newton step runs the shared restoring divider
//   followed by an update state. There are 1 to 20 steps; a zero sum skips
//   the divider and goes straight to the result.
//   s_axis_tready is high only while the sequencer is idle, so one sample is
//   processed at a time.
// Reset:
//   synchronous active-low reset returns the sequencer to idle, drops the
//   result word and sets the full-scale code to the 2 g range.
// Stalls:
//   a finished result sits in the output register while the next sample is
//   accepted; a further result waits in its final state until m_axis drains.
// ---------------------------------------------------------------------------
module accel_sample_magnitude_orientation_core
    import asmo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,      // full_scale_code
    // sample input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // x_raw, y_raw, z_raw
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata     // x_mg, y_mg, z_mg, magnitude, facing, zero pad
);

`include "assert_macros.svh"

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [4:0] LAST_STEP = 5'(NEWTON_MAX_STEPS - 1);

    logic [2:0]  r_state;
    logic [1:0]  r_fs_code;
    t_mg         r_x;
    t_mg         r_y;
    t_mg         r_z;
    logic [1:0]  r_sq_idx;
    logic [31:0] r_sum;
    logic [31:0] r_root;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [4:0]  r_bit;
    logic [4:0]  r_step;
    logic        r_out_valid;
    logic [71:0] r_out_data;

    t_mg         sq_sel;
    logic [15:0] sq_abs;
    logic [31:0] sq_prod;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [32:0] n_rem;
    logic [32:0] root_avg;
    logic [31:0] n_root;
    logic [15:0] mag_sat;
    logic        done_fire;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // shared squaring multiplier on the axis magnitude
    always_comb begin
        unique case (r_sq_idx)
            2'd0:    sq_sel = r_x;
            2'd1:    sq_sel = r_y;
            default: sq_sel = r_z;
        endcase
    end
    assign sq_abs  = abs_mg(sq_sel);
    assign sq_prod = {16'd0, sq_abs} * {16'd0, sq_abs};

    // one restoring division bit per cycle
    assign rem_sh = {r_rem, r_quo[31]};
    assign rem_ge = (rem_sh >= {1'b0, r_root});
    assign n_rem  = rem_ge ? (rem_sh - {1'b0, r_root}) : rem_sh;

    // newton update r = (r + s / r) >> 1
    assign root_avg = {1'b0, r_root} + {1'b0, r_quo};
    assign n_root   = root_avg[32:1];

    assign mag_sat   = (r_root > 32'(MAG_SAT)) ? MAG_SAT : r_root[15:0];
    assign done_fire = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_code <= FS_2G;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fs_code <= i_cfg_data;
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (r_sq_idx == 2'd2) begin
                        r_state <= ((r_sum + sq_prod) == 32'd0) ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_bit == 5'd31) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (n_root == r_root || n_root == 32'd0 || r_step == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DONE: begin
                    if (done_fire) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x      <= scale_axis(s_axis_tdata[15:0], r_fs_code);
                r_y      <= scale_axis(s_axis_tdata[31:16], r_fs_code);
                r_z      <= scale_axis(s_axis_tdata[47:32], r_fs_code);
                r_sq_idx <= 2'd0;
                r_sum    <= 32'd0;
                r_step   <= 5'd0;
            end
            ST_SQ: begin
                r_sum    <= r_sum + sq_prod;
                r_root   <= r_sum + sq_prod;
                r_quo    <= r_sum + sq_prod;
                r_rem    <= 32'd0;
                r_bit    <= 5'd0;
                r_sq_idx <= r_sq_idx + 2'd1;
            end
            ST_DIV: begin
                r_rem <= n_rem[31:0];
                r_quo <= {r_quo[30:0], rem_ge};
                r_bit <= r_bit + 5'd1;
            end
            ST_UPD: begin
                r_root <= n_root;
                r_quo  <= r_sum;
                r_rem  <= 32'd0;
                r_bit  <= 5'd0;
                r_step <= r_step + 5'd1;
            end
            ST_DONE: begin
                if (done_fire) begin
                    r_out_data <= {5'd0, facing_code(r_x, r_y, r_z), mag_sat,
                                   r_z, r_y, r_x};
                end
            end
            default: begin
                r_bit <= 5'd0;
            end
        endcase
    end

    // checks
    `ASSERT_NEVER(a_step_bound, i_clk, i_rst_n, r_step > 5'(NEWTON_MAX_STEPS))
    `ASSERT_NEVER(a_div_nonzero, i_clk, i_rst_n, (r_state == ST_DIV) && (r_root == 32'd0))
    `ASSERT_PROP(a_root_le_sum, i_clk, i_rst_n, (r_state == ST_DONE) |-> (r_root <= r_sum))
    `ASSERT_PROP(a_zero_sum_root, i_clk, i_rst_n, ((r_state == ST_DONE) && (r_sum == 32'd0)) |-> (r_root == 32'd0))
    `ASSERT_PROP(a_done_loads, i_clk, i_rst_n, done_fire |=> (r_out_valid && r_state == ST_IDLE))

endmodule
